// ===== hw/rtl/pbpm_pkg.sv =====
// shared constants, codes and interface types for the packet buffer pool manager
package pbpm_pkg;

   localparam int POOL_DEPTH = 16;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

   // request actions
   localparam logic [2:0] ACT_ALLOC = 3'd0;
   localparam logic [2:0] ACT_FREE  = 3'd1;
   localparam logic [2:0] ACT_PURGE = 3'd2;
   localparam logic [2:0] ACT_SET   = 3'd3;
   localparam logic [2:0] ACT_PICK  = 3'd4;
   localparam logic [2:0] ACT_COUNT = 3'd5;

   // response status
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NOT_SYNCED   = 3'd1;
   localparam logic [2:0] ST_RESERVE      = 3'd2;
   localparam logic [2:0] ST_FULL         = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX    = 3'd4;
   localparam logic [2:0] ST_NONE         = 3'd5;
   localparam logic [2:0] ST_FREED_UNUSED = 3'd6;

   // csr indexes
   localparam logic [2:0] CSR_NULL_ID    = 3'd0;
   localparam logic [2:0] CSR_POOL_OWNER = 3'd1;
   localparam logic [2:0] CSR_MAC_ID     = 3'd2;
   localparam logic [2:0] CSR_SCHED_RES  = 3'd3;
   localparam logic [2:0] CSR_TO_MAC     = 3'd4;
   localparam logic [2:0] CSR_RESERVED   = 3'd5;
   localparam logic [2:0] CSR_REQ_TYPE   = 3'd6;
   localparam logic [2:0] CSR_RSP_TYPE   = 3'd7;

   // reset value of null_id, also the reset content of creator and owner
   localparam logic [7:0] NULL_ID_RST = 8'd0;

   typedef struct packed {
      logic [7:0] null_id;
      logic [7:0] pool_owner_id;
      logic [7:0] mac_id;
      logic [7:0] sched_res_id;
      logic [7:0] to_mac_owner_id;
      logic [6:0] reserved_entries;
      logic [7:0] request_type;
      logic [7:0] response_type;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_free;
   } sts_type;

endpackage

// ===== hw/rtl/pbpm_csr.sv =====
// configuration register file of the packet buffer pool manager
module pbpm_csr
   import pbpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   // no write beat is taken while reset loads the defaults
   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NULL_ID:    cfg_in.null_id          = csr_wdata;
            CSR_POOL_OWNER: cfg_in.pool_owner_id    = csr_wdata;
            CSR_MAC_ID:     cfg_in.mac_id           = csr_wdata;
            CSR_SCHED_RES:  cfg_in.sched_res_id     = csr_wdata;
            CSR_TO_MAC:     cfg_in.to_mac_owner_id  = csr_wdata;
            CSR_RESERVED:   cfg_in.reserved_entries = csr_wdata[6:0];
            CSR_REQ_TYPE:   cfg_in.request_type     = csr_wdata;
            CSR_RSP_TYPE:   cfg_in.response_type    = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.null_id          <= NULL_ID_RST;
         cfg_ff.pool_owner_id    <= 8'd1;
         cfg_ff.mac_id           <= 8'd4;
         cfg_ff.sched_res_id     <= 8'd8;
         cfg_ff.to_mac_owner_id  <= 8'd2;
         cfg_ff.reserved_entries <= 7'd5;
         cfg_ff.request_type     <= 8'd1;
         cfg_ff.response_type    <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/pbpm_ctrl.sv =====
// sequencing state machine: accept, scan the pool, finish and post the response
module pbpm_ctrl
   import pbpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   // no request beat is taken while in reset
   assign req_stall = reset || (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.finish    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the response register can take the beat
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/pbpm_dp.sv =====
// descriptor pool storage, scan accumulators and response register
module pbpm_dp
   import pbpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_action,
   input  logic        req_synced,
   input  logic [7:0]  req_creator,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_owner_value,
   input  logic [7:0]  req_message_type,
   input  logic [63:0] req_hop_address,
   input  logic        req_hop_is_long,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_result_index,
   output logic [6:0]  rsp_match_count
);

   // latched request
   logic [2:0]  act_ff;
   logic        synced_ff;
   logic [7:0]  creator_ff;
   logic [7:0]  index_ff;
   logic [7:0]  owner_val_ff;
   logic [7:0]  mtype_ff;
   logic [63:0] addr_ff;
   logic        long_ff;

   // pool storage
   logic [7:0]  entry_creator_ff  [POOL_DEPTH];
   logic [7:0]  entry_owner_ff    [POOL_DEPTH];
   logic [7:0]  entry_msg_type_ff [POOL_DEPTH];
   logic [63:0] entry_hop_addr_ff [POOL_DEPTH];
   logic        entry_hop_long_ff [POOL_DEPTH];

   // scan state
   logic [IDX_W-1:0] scan_ff;
   logic [CNT_W-1:0] low_cnt_ff, low_cnt_in;
   logic [CNT_W-1:0] req_cnt_ff, req_cnt_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             resp_found_ff, resp_found_in;
   logic [IDX_W-1:0] resp_idx_ff, resp_idx_in;
   logic             any_found_ff, any_found_in;
   logic [IDX_W-1:0] any_idx_ff, any_idx_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_index_ff, rsp_index_in;
   logic [6:0]  rsp_count_ff, rsp_count_in;

   logic [IDX_W-1:0] idx_lo;
   logic             bad_index;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_creator;
   logic [7:0]       rd_owner;
   logic [7:0]       rd_mtype;
   logic             addr_hit;
   logic             to_mac_hit;
   logic [7:0]       low_sum;

   logic             wr_release;
   logic             wr_alloc;
   logic             wr_set;
   logic [IDX_W-1:0] wr_addr;

   assign idx_lo    = index_ff[IDX_W-1:0];
   assign bad_index = (index_ff >= 8'(POOL_DEPTH));
   assign rd_addr   = cmd.scan_step ? scan_ff : idx_lo;

   assign rd_creator = entry_creator_ff[rd_addr];
   assign rd_owner   = entry_owner_ff[rd_addr];
   assign rd_mtype   = entry_msg_type_ff[rd_addr];
   assign addr_hit   = (entry_hop_long_ff[rd_addr] == long_ff) &&
                       (entry_hop_addr_ff[rd_addr] == addr_ff);
   assign to_mac_hit = (rd_owner == cfg.to_mac_owner_id) && addr_hit;

   assign low_sum = 8'(low_cnt_ff) + 8'(cfg.reserved_entries);

   assign sts.scan_last = (scan_ff == IDX_W'(POOL_DEPTH - 1));
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // scan accumulators
   always_comb begin
      low_cnt_in    = low_cnt_ff;
      req_cnt_in    = req_cnt_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      resp_found_in = resp_found_ff;
      resp_idx_in   = resp_idx_ff;
      any_found_in  = any_found_ff;
      any_idx_in    = any_idx_ff;
      if (cmd.load) begin
         low_cnt_in    = '0;
         req_cnt_in    = '0;
         free_found_in = 1'b0;
         free_idx_in   = '0;
         resp_found_in = 1'b0;
         resp_idx_in   = '0;
         any_found_in  = 1'b0;
         any_idx_in    = '0;
      end else if (cmd.scan_step) begin
         if (rd_creator > cfg.sched_res_id) begin
            low_cnt_in = low_cnt_ff + 1'b1;
         end
         if (!free_found_ff && (rd_owner == cfg.null_id)) begin
            free_found_in = 1'b1;
            free_idx_in   = scan_ff;
         end
         if (!resp_found_ff && to_mac_hit && (rd_creator == cfg.sched_res_id) &&
             (rd_mtype == cfg.response_type)) begin
            resp_found_in = 1'b1;
            resp_idx_in   = scan_ff;
         end
         if (!any_found_ff && to_mac_hit) begin
            any_found_in = 1'b1;
            any_idx_in   = scan_ff;
         end
         if (to_mac_hit && (rd_creator == cfg.sched_res_id) &&
             (rd_mtype == cfg.request_type)) begin
            req_cnt_in = req_cnt_ff + 1'b1;
         end
      end
   end

   // action outcome and pool write select
   always_comb begin
      wr_release    = 1'b0;
      wr_alloc      = 1'b0;
      wr_set        = 1'b0;
      wr_addr       = scan_ff;
      rsp_status_in = ST_OK;
      rsp_index_in  = '0;
      rsp_count_in  = '0;
      if (cmd.scan_step) begin
         if ((act_ff == ACT_PURGE) && (rd_creator == creator_ff) &&
             (rd_owner != cfg.mac_id)) begin
            wr_release = 1'b1;
         end
      end else begin
         case (act_ff)
            ACT_ALLOC: begin
               if (!synced_ff && (creator_ff > cfg.mac_id)) begin
                  rsp_status_in = ST_NOT_SYNCED;
               end else if ((low_sum > 8'(POOL_DEPTH)) &&
                            (creator_ff > cfg.sched_res_id)) begin
                  rsp_status_in = ST_RESERVE;
               end else if (free_found_ff) begin
                  wr_alloc     = cmd.finish;
                  wr_addr      = free_idx_ff;
                  rsp_index_in = 8'(free_idx_ff);
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end
            ACT_FREE: begin
               wr_addr = idx_lo;
               if (bad_index) begin
                  rsp_status_in = ST_BAD_INDEX;
               end else begin
                  wr_release   = cmd.finish;
                  rsp_index_in = index_ff;
                  if (rd_owner == cfg.null_id) begin
                     rsp_status_in = ST_FREED_UNUSED;
                  end
               end
            end
            ACT_SET: begin
               wr_addr = idx_lo;
               if (bad_index) begin
                  rsp_status_in = ST_BAD_INDEX;
               end else begin
                  wr_set       = cmd.finish;
                  rsp_index_in = index_ff;
               end
            end
            ACT_PICK: begin
               // short addresses never pick
               if (long_ff && resp_found_ff) begin
                  rsp_index_in = 8'(resp_idx_ff);
               end else if (long_ff && any_found_ff) begin
                  rsp_index_in = 8'(any_idx_ff);
               end else begin
                  rsp_status_in = ST_NONE;
               end
            end
            ACT_COUNT: begin
               rsp_count_in = 7'(req_cnt_ff);
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff       <= req_action;
         synced_ff    <= req_synced;
         creator_ff   <= req_creator;
         index_ff     <= req_entry_index;
         owner_val_ff <= req_owner_value;
         mtype_ff     <= req_message_type;
         addr_ff      <= req_hop_address;
         long_ff      <= req_hop_is_long;
      end
      low_cnt_ff    <= low_cnt_in;
      req_cnt_ff    <= req_cnt_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      resp_found_ff <= resp_found_in;
      resp_idx_ff   <= resp_idx_in;
      any_found_ff  <= any_found_in;
      any_idx_ff    <= any_idx_in;
      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            scan_ff <= '0;
         end else if (cmd.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < POOL_DEPTH; k++) begin
            entry_creator_ff[k]  <= NULL_ID_RST;
            entry_owner_ff[k]    <= NULL_ID_RST;
            entry_msg_type_ff[k] <= '0;
            entry_hop_addr_ff[k] <= '0;
            entry_hop_long_ff[k] <= 1'b0;
         end
      end else if (wr_release) begin
         entry_creator_ff[wr_addr]  <= cfg.null_id;
         entry_owner_ff[wr_addr]    <= cfg.null_id;
         entry_hop_long_ff[wr_addr] <= 1'b0;
      end else if (wr_alloc) begin
         entry_creator_ff[wr_addr] <= creator_ff;
         entry_owner_ff[wr_addr]   <= cfg.pool_owner_id;
      end else if (wr_set) begin
         entry_owner_ff[wr_addr]    <= owner_val_ff;
         entry_msg_type_ff[wr_addr] <= mtype_ff;
         entry_hop_addr_ff[wr_addr] <= addr_ff;
         entry_hop_long_ff[wr_addr] <= long_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_match_count  = rsp_count_ff;

endmodule

// ===== hw/rtl/packet_buffer_pool_manager_top.sv =====
// top level of the packet buffer pool manager
//
//   channel   dir   handshake              payload
//   req_      in    req_valid / req_stall  action, synced, creator, entry_index, owner_value,
//                                          message_type, hop_address, hop_is_long
//   rsp_      out   rsp_valid / rsp_stall  status, result_index, match_count
//   csr_      in    csr_valid / csr_ready  index, wdata
//
// every request runs through accept, one pass over all POOL_DEPTH entries
// (one entry per cycle through the single pool read port), and finish
// a response sits in an output register; the next request is accepted while it waits,
// but that request holds in its finish cycle until the earlier beat is taken
// synchronous active-high reset clears the pool and loads the register defaults at once
module packet_buffer_pool_manager_top
   import pbpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic        req_synced,
   input  logic [7:0]  req_creator,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_owner_value,
   input  logic [7:0]  req_message_type,
   input  logic [63:0] req_hop_address,
   input  logic        req_hop_is_long,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_result_index,
   output logic [6:0]  rsp_match_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   pbpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pbpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pbpm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_synced       (req_synced),
      .req_creator      (req_creator),
      .req_entry_index  (req_entry_index),
      .req_owner_value  (req_owner_value),
      .req_message_type (req_message_type),
      .req_hop_address  (req_hop_address),
      .req_hop_is_long  (req_hop_is_long),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_match_count  (rsp_match_count)
   );

endmodule

// ===== tb/packet_buffer_pool_manager_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the packet buffer pool manager top level
module packet_buffer_pool_manager_top_tb;
   import pbpm_pkg::*;

   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;
   localparam int SETTLE_CYCLES      = 24;
   localparam int WATCHDOG_LIMIT     = 1000;
   localparam int RANDOM_PHASES      = 5;
   localparam int RANDOM_PHASE_ITEMS = 100;
   localparam cfg_type CFG_DEFAULT =
      {NULL_ID_RST, 8'd1, 8'd4, 8'd8, 8'd2, 7'd5, 8'd1, 8'd2};

   typedef struct packed {
      logic [2:0]  action;
      logic        synced;
      logic [7:0]  creator;
      logic [7:0]  entry_index;
      logic [7:0]  owner_value;
      logic [7:0]  message_type;
      logic [63:0] hop_address;
      logic        hop_is_long;
   } pool_op_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] result_index;
      logic [6:0] match_count;
   } pool_result_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action       = '0;
   logic        req_synced       = 1'b0;
   logic [7:0]  req_creator      = '0;
   logic [7:0]  req_entry_index  = '0;
   logic [7:0]  req_owner_value  = '0;
   logic [7:0]  req_message_type = '0;
   logic [63:0] req_hop_address  = '0;
   logic        req_hop_is_long  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_result_index;
   logic [6:0]  rsp_match_count;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index        = '0;
   logic [7:0]  csr_wdata        = '0;

   // predictor copy of the registers and the descriptor pool
   cfg_type     regs;
   logic [7:0]  pool_creator  [POOL_DEPTH];
   logic [7:0]  pool_owner    [POOL_DEPTH];
   logic [7:0]  pool_mtype    [POOL_DEPTH];
   logic [63:0] pool_hop_addr [POOL_DEPTH];
   logic        pool_hop_long [POOL_DEPTH];

   pool_result_type pool_results_due [$];
   pool_result_type result_due;
   logic [63:0]     hop_book [4];
   bit              idle_on     = 1'b1;
   int              errors      = 0;
   int              idle_cycles = 0;

   packet_buffer_pool_manager_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_synced       (req_synced),
      .req_creator      (req_creator),
      .req_entry_index  (req_entry_index),
      .req_owner_value  (req_owner_value),
      .req_message_type (req_message_type),
      .req_hop_address  (req_hop_address),
      .req_hop_is_long  (req_hop_is_long),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_match_count  (rsp_match_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void release_entry(input int k);
      pool_creator[k]  = regs.null_id;
      pool_owner[k]    = regs.null_id;
      pool_hop_long[k] = 1'b0;
   endfunction

   function automatic pool_result_type pool_apply(input pool_op_type op);
      pool_result_type res;
      int              low_prio;
      int              k;
      bit              found;
      res = '0;
      found = 1'b0;
      case (op.action)
         ACT_ALLOC: begin
            low_prio = 0;
            for (k = 0; k < POOL_DEPTH; k++)
               if (pool_creator[k] > regs.sched_res_id) low_prio++;
            if (!op.synced && op.creator > regs.mac_id) begin
               res.status = ST_NOT_SYNCED;
            end else if (low_prio + int'(regs.reserved_entries) > POOL_DEPTH &&
                         op.creator > regs.sched_res_id) begin
               res.status = ST_RESERVE;
            end else begin
               res.status = ST_FULL;
               for (k = 0; k < POOL_DEPTH; k++) begin
                  if (!found && pool_owner[k] == regs.null_id) begin
                     found = 1'b1;
                     pool_creator[k] = op.creator;
                     pool_owner[k] = regs.pool_owner_id;
                     res.status = ST_OK;
                     res.result_index = 8'(k);
                  end
               end
            end
         end
         ACT_FREE: begin
            if (op.entry_index >= POOL_DEPTH) begin
               res.status = ST_BAD_INDEX;
            end else begin
               if (pool_owner[op.entry_index] == regs.null_id) res.status = ST_FREED_UNUSED;
               release_entry(int'(op.entry_index));
               res.result_index = op.entry_index;
            end
         end
         ACT_PURGE: begin
            for (k = 0; k < POOL_DEPTH; k++)
               if (pool_creator[k] == op.creator && pool_owner[k] != regs.mac_id)
                  release_entry(k);
         end
         ACT_SET: begin
            if (op.entry_index >= POOL_DEPTH) begin
               res.status = ST_BAD_INDEX;
            end else begin
               pool_owner[op.entry_index]    = op.owner_value;
               pool_mtype[op.entry_index]    = op.message_type;
               pool_hop_addr[op.entry_index] = op.hop_address;
               pool_hop_long[op.entry_index] = op.hop_is_long;
               res.result_index = op.entry_index;
            end
         end
         ACT_PICK: begin
            // cell responses to this neighbor win over any other entry for it
            if (op.hop_is_long) begin
               for (k = 0; k < POOL_DEPTH; k++) begin
                  if (!found && pool_owner[k] == regs.to_mac_owner_id &&
                      pool_creator[k] == regs.sched_res_id &&
                      pool_hop_long[k] == op.hop_is_long &&
                      pool_hop_addr[k] == op.hop_address &&
                      pool_mtype[k] == regs.response_type) begin
                     found = 1'b1;
                     res.result_index = 8'(k);
                  end
               end
               for (k = 0; k < POOL_DEPTH; k++) begin
                  if (!found && pool_owner[k] == regs.to_mac_owner_id &&
                      pool_hop_long[k] == op.hop_is_long &&
                      pool_hop_addr[k] == op.hop_address) begin
                     found = 1'b1;
                     res.result_index = 8'(k);
                  end
               end
            end
            if (!found) res.status = ST_NONE;
         end
         ACT_COUNT: begin
            for (k = 0; k < POOL_DEPTH; k++)
               if (pool_owner[k] == regs.to_mac_owner_id &&
                   pool_creator[k] == regs.sched_res_id &&
                   pool_mtype[k] == regs.request_type &&
                   pool_hop_long[k] == op.hop_is_long &&
                   pool_hop_addr[k] == op.hop_address)
                  res.match_count = res.match_count + 7'd1;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic pool_op_type mk_op(input logic [2:0] action, input logic synced,
                                         input logic [7:0] creator, input logic [7:0] idx,
                                         input logic [7:0] owner, input logic [7:0] mtype,
                                         input logic [63:0] addr, input logic is_long);
      return {action, synced, creator, idx, owner, mtype, addr, is_long};
   endfunction

   function automatic logic [7:0] pick_id();
      return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
   endfunction

   // ids lean toward the register values so that matches are frequent
   function automatic pool_op_type random_op();
      pool_op_type op;
      int          roll;
      roll = $urandom_range(99);
      if (roll < 22)      op.action = ACT_ALLOC;
      else if (roll < 40) op.action = ACT_FREE;
      else if (roll < 47) op.action = ACT_PURGE;
      else if (roll < 70) op.action = ACT_SET;
      else if (roll < 83) op.action = ACT_PICK;
      else if (roll < 96) op.action = ACT_COUNT;
      else                op.action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
      op.synced = ($urandom_range(3) != 0);
      case ($urandom_range(4))
         0:       op.creator = regs.mac_id;
         1, 2:    op.creator = regs.sched_res_id;
         3:       op.creator = regs.sched_res_id + 8'd1;
         default: op.creator = pick_id();
      endcase
      op.entry_index = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(POOL_DEPTH - 1));
      case ($urandom_range(4))
         0, 1:    op.owner_value = regs.to_mac_owner_id;
         2:       op.owner_value = regs.mac_id;
         3:       op.owner_value = regs.null_id;
         default: op.owner_value = pick_id();
      endcase
      case ($urandom_range(3))
         0:       op.message_type = regs.request_type;
         1:       op.message_type = regs.response_type;
         2:       op.message_type = regs.pool_owner_id;
         default: op.message_type = pick_id();
      endcase
      op.hop_address = ($urandom_range(7) == 0) ? {$urandom, $urandom}
                                                : hop_book[$urandom_range(3)];
      if (op.action == ACT_PICK || op.action == ACT_SET)
         op.hop_is_long = ($urandom_range(3) != 0);
      else
         op.hop_is_long = 1'($urandom_range(1));
      return op;
   endfunction

   // valid stays high into the next beat unless a gap is drawn
   task automatic send_req(input pool_op_type op);
      req_valid        <= 1'b1;
      req_action       <= op.action;
      req_synced       <= op.synced;
      req_creator      <= op.creator;
      req_entry_index  <= op.entry_index;
      req_owner_value  <= op.owner_value;
      req_message_type <= op.message_type;
      req_hop_address  <= op.hop_address;
      req_hop_is_long  <= op.hop_is_long;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pool_results_due.push_back(pool_apply(op));
      if (idle_on && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   endtask

   task automatic drain_pool_ops();
      req_valid <= 1'b0;
      while (pool_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_regs(input cfg_type c);
      logic [7:0] vals [8];
      int         i;
      vals[CSR_NULL_ID]    = c.null_id;
      vals[CSR_POOL_OWNER] = c.pool_owner_id;
      vals[CSR_MAC_ID]     = c.mac_id;
      vals[CSR_SCHED_RES]  = c.sched_res_id;
      vals[CSR_TO_MAC]     = c.to_mac_owner_id;
      vals[CSR_RESERVED]   = {1'b0, c.reserved_entries};
      vals[CSR_REQ_TYPE]   = c.request_type;
      vals[CSR_RSP_TYPE]   = c.response_type;
      for (i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (3'(i))
            CSR_NULL_ID:    regs.null_id          = vals[i];
            CSR_POOL_OWNER: regs.pool_owner_id    = vals[i];
            CSR_MAC_ID:     regs.mac_id           = vals[i];
            CSR_SCHED_RES:  regs.sched_res_id     = vals[i];
            CSR_TO_MAC:     regs.to_mac_owner_id  = vals[i];
            CSR_RESERVED:   regs.reserved_entries = vals[i][6:0];
            CSR_REQ_TYPE:   regs.request_type     = vals[i];
            CSR_RSP_TYPE:   regs.response_type    = vals[i];
            default: begin
            end
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_alloc_gate();
      send_req(mk_op(ACT_ALLOC, 1'b0, 8'hFF, '0, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_ALLOC, 1'b0, regs.mac_id, '0, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_ALLOC, 1'b1, regs.sched_res_id, '0, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_ALLOC, 1'b1, regs.sched_res_id + 8'd1, '0, '0, '0, '0, 1'b0));
   endtask

   task automatic test_free_by_index();
      send_req(mk_op(ACT_FREE, 1'b1, '0, 8'd2, '0, '0, '0, 1'b0));
      // second free of the same entry reports it unused
      send_req(mk_op(ACT_FREE, 1'b1, '0, 8'd2, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_FREE, 1'b1, '0, 8'hFF, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_FREE, 1'b1, '0, 8'(POOL_DEPTH), '0, '0, '0, 1'b0));
   endtask

   task automatic test_pick_and_count();
      send_req(mk_op(ACT_SET, 1'b1, '0, 8'd1, regs.to_mac_owner_id, regs.response_type,
                     '1, 1'b1));
      send_req(mk_op(ACT_SET, 1'b1, '0, 8'd0, regs.to_mac_owner_id, regs.request_type,
                     '1, 1'b1));
      // response from the scheduler beats the lower entry
      send_req(mk_op(ACT_PICK, 1'b1, '0, '0, '0, '0, '1, 1'b1));
      send_req(mk_op(ACT_PICK, 1'b1, '0, '0, '0, '0, '1, 1'b0));
      send_req(mk_op(ACT_SET, 1'b1, '0, 8'd200, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_SET, 1'b1, '0, 8'd1, regs.to_mac_owner_id, regs.request_type,
                     '1, 1'b1));
      send_req(mk_op(ACT_COUNT, 1'b1, '0, '0, '0, '0, '1, 1'b1));
      send_req(mk_op(ACT_PICK, 1'b1, '0, '0, '0, '0, '1, 1'b1));
      send_req(mk_op(ACT_COUNT, 1'b1, '0, '0, '0, '0, '0, 1'b0));
   endtask

   task automatic test_purge();
      send_req(mk_op(ACT_PURGE, 1'b1, regs.sched_res_id, '0, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_SET, 1'b1, '0, 8'd0, regs.mac_id, '0, '0, 1'b0));
      // entries the mac owns survive a purge
      send_req(mk_op(ACT_PURGE, 1'b1, regs.mac_id, '0, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_FREE, 1'b1, '0, 8'd0, '0, '0, '0, 1'b0));
   endtask

   task automatic test_reg_extremes();
      cfg_type c;
      c = CFG_DEFAULT;
      c.reserved_entries = 7'd64;
      drain_pool_ops();
      load_regs(c);
      send_req(mk_op(ACT_ALLOC, 1'b1, regs.sched_res_id + 8'd1, '0, '0, '0, '0, 1'b0));
      // no stored owner equals the new null id, so the pool looks full
      c = CFG_DEFAULT;
      c.null_id = 8'hFF;
      drain_pool_ops();
      load_regs(c);
      send_req(mk_op(ACT_ALLOC, 1'b1, 8'd0, '0, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_FREE, 1'b1, '0, 8'd3, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_ALLOC, 1'b1, 8'd0, '0, '0, '0, '0, 1'b0));
      send_req(mk_op(ACT_SPARE_A, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1, 1'b1));
      send_req(mk_op(ACT_SPARE_B, 1'b0, '0, '0, '0, '0, '0, 1'b0));
      drain_pool_ops();
      load_regs(CFG_DEFAULT);
   endtask

   task automatic test_random_traffic();
      cfg_type phase_regs;
      int      phase;
      int      n;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            1: phase_regs = '0;
            3: phase_regs = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd64, 8'hFF, 8'hFF};
            default: begin
               phase_regs.null_id          = pick_id();
               phase_regs.pool_owner_id    = pick_id();
               phase_regs.mac_id           = pick_id();
               phase_regs.sched_res_id     = pick_id();
               phase_regs.to_mac_owner_id  = pick_id();
               phase_regs.reserved_entries = ($urandom_range(3) == 0) ? 7'($urandom_range(64))
                                                                      : 7'($urandom_range(16));
               phase_regs.request_type     = pick_id();
               phase_regs.response_type    = pick_id();
            end
         endcase
         drain_pool_ops();
         // one phase runs both channels flat out
         idle_on = (phase != 2);
         load_regs(phase_regs);
         for (n = 0; n < RANDOM_PHASE_ITEMS; n++) send_req(random_op());
      end
      idle_on = 1'b1;
   endtask

   always @(posedge clock) rsp_stall <= idle_on && ($urandom_range(99) < 36);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pool_results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, actual status %0d index %0d count %0d",
                     $time, rsp_status, rsp_result_index, rsp_match_count);
         end else begin
            result_due = pool_results_due.pop_front();
            if ({rsp_status, rsp_result_index, rsp_match_count} !== result_due) begin
               errors++;
               $display("%0t: mismatch, expected status %0d index %0d count %0d, %s %0d %0d %0d",
                        $time, result_due.status, result_due.result_index,
                        result_due.match_count, "actual status/index/count",
                        rsp_status, rsp_result_index, rsp_match_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      regs = CFG_DEFAULT;
      for (int k = 0; k < POOL_DEPTH; k++) begin
         pool_creator[k]  = NULL_ID_RST;
         pool_owner[k]    = NULL_ID_RST;
         pool_mtype[k]    = '0;
         pool_hop_addr[k] = '0;
         pool_hop_long[k] = 1'b0;
      end
      hop_book[0] = '0;
      hop_book[1] = '1;
      hop_book[2] = {$urandom, $urandom};
      hop_book[3] = {$urandom, $urandom};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_alloc_gate();
      test_free_by_index();
      test_pick_and_count();
      test_purge();
      test_reg_extremes();
      test_random_traffic();
      drain_pool_ops();
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pbpm_pkg.sv
hw/rtl/pbpm_csr.sv
hw/rtl/pbpm_ctrl.sv
hw/rtl/pbpm_dp.sv
hw/rtl/packet_buffer_pool_manager_top.sv
tb/packet_buffer_pool_manager_top_tb.sv
